// ----- hdl/axis_drive_ramp_model_core_defines.svh -----
// Assertion macros used by the checker file of the axis drive ramp model
`ifndef AXIS_DRIVE_RAMP_MODEL_CORE_DEFINES_SVH
`define AXIS_DRIVE_RAMP_MODEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ADRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adrm check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ADRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adrm check failed");

`endif

// ----- hdl/adrm_pkg.sv -----
// Package with widths, register indexes, reset values and constants of the axis ramp model
`default_nettype none

package adrm_pkg;

    // Field widths
    localparam int VAL_W      = 32;
    localparam int RATE_W     = 31;
    localparam int COEFF_W    = 17;
    localparam int Q16_W      = 16;
    localparam int IDLE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Serial multiplier shape: signed multiplicand, unsigned multiplier, digit
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int MUL_DIG_W = 4;

    // Wide intermediate widths for the rounding shift
    localparam int PROD_W = 51;
    localparam int SUM_W  = 35;

    // Default stop timeout in ticks
    localparam int STOP_TICKS_DEF = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_FS    = 3'd6;

    // Register reset values
    localparam logic [COEFF_W-1:0] FILTER_COEFF_RST = 17'd649;
    localparam logic [Q16_W-1:0]   TICK_PERIOD_RST  = 16'd655;
    localparam logic [Q16_W-1:0]   ZERO_BAND_RST    = 16'd1;

    // Unity coefficient in Q1.16
    localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;

    // Half LSB of a Q16 shift, for round half up
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 51'sd32768;

    // Torque: (fs * pct + 5) / 10 as multiply by ceil(2^23 / 10), then shift
    localparam int TQ_NUM_W = 20;
    localparam int TQ_SHIFT = 23;
    localparam logic [TQ_NUM_W-1:0] TQ_RECIP10 = 20'd838861;
    localparam logic [TQ_NUM_W-1:0] TQ_ROUND   = 20'd5;

    // Saturation bounds of the signed 32-bit range in the wide sum
    localparam logic signed [SUM_W-1:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -35'sd2147483648;

endpackage

`default_nettype wire

// ----- hdl/adrm_if.sv -----
// Valid/ready channel interfaces for ticks, results and register writes
`default_nettype none

interface adrm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [adrm_pkg::VAL_W-1:0]  speed_ref;
    logic                               brake_open;
    logic                               fwd_endstop;
    logic                               rev_endstop;

    modport source (output valid, speed_ref, brake_open, fwd_endstop, rev_endstop,
                    input ready);
    modport sink   (input valid, speed_ref, brake_open, fwd_endstop, rev_endstop,
                    output ready);
endinterface

interface adrm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [adrm_pkg::VAL_W-1:0]   accel_cmd;
    logic signed [adrm_pkg::VAL_W-1:0]   accel_filtered;
    logic signed [adrm_pkg::VAL_W-1:0]   speed_out;
    logic        [adrm_pkg::Q16_W-1:0]   torque_out;
    logic                                speed_forced_zero;

    modport source (output valid, accel_cmd, accel_filtered, speed_out, torque_out,
                    speed_forced_zero, input ready);
    modport sink   (input valid, accel_cmd, accel_filtered, speed_out, torque_out,
                    speed_forced_zero, output ready);
endinterface

interface adrm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [adrm_pkg::CFG_IDX_W-1:0]       index;
    logic [adrm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/adrm_serial_mul.sv -----
// Digit-serial signed-by-unsigned multiplier, one multiplier digit per cycle, LSB first
`default_nettype none

module adrm_serial_mul #(
    parameter int A_W   = adrm_pkg::MUL_A_W,
    parameter int B_W   = adrm_pkg::MUL_B_W,
    parameter int DIG_W = adrm_pkg::MUL_DIG_W
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_start,
    input  wire  signed [A_W-1:0]                      i_a,
    input  wire         [B_W-1:0]                      i_b,
    output logic                                       o_busy,
    output logic                                       o_done,
    output logic signed [A_W+DIG_W+1+((B_W+DIG_W-1)/DIG_W)*DIG_W-1:0] o_prod
);

    localparam int NDIG  = (B_W + DIG_W - 1) / DIG_W;
    localparam int LO_W  = NDIG * DIG_W;
    localparam int ACC_W = A_W + DIG_W + 1;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic signed [A_W-1:0]   r_a;
    logic        [LO_W-1:0]  r_b, n_b;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic        [LO_W-1:0]  r_lo, n_lo;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_busy;

    logic        [DIG_W-1:0] digit;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] sum;

    // Add one partial product and shift the finished low digit out
    always_comb begin
        digit = r_b[DIG_W-1:0];
        term  = $signed({{(ACC_W-A_W){r_a[A_W-1]}}, r_a})
              * $signed({{(ACC_W-DIG_W){1'b0}}, digit});
        sum   = r_acc + term;
        n_acc = sum >>> DIG_W;
        n_lo  = {sum[DIG_W-1:0], r_lo[LO_W-1:DIG_W]};
        n_b   = r_b >> DIG_W;
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NDIG);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= {{(LO_W-B_W){1'b0}}, i_b};
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_b   <= n_b;
            r_acc <= n_acc;
            r_lo  <= n_lo;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == CNT_W'(1));
    assign o_prod = {r_acc, r_lo};

endmodule

`default_nettype wire

// ----- hdl/axis_drive_ramp_model_core.sv -----
// Top level of the axis drive ramp model: register file, tick sequencer and result register
`default_nettype none

// One simulated motor axis, advanced by one tick per input word. Each tick picks
// an acceleration command from the speed error against a dead band, clamps it at
// the end stops, lags it, zeroes small values and integrates it into speed; a
// run of zero references forces speed to zero. Command, filtered and speed
// values are Q16.16. A tick's result word is loaded in the update state, after
// the prepare, first multiply, filter, launch, second multiply and delta states;
// the next tick can be accepted the cycle after that, so ticks never overlap. The
// shared 4-bit digit-serial multiplier runs twice per tick (lag filter, then
// speed integration) at five digits each. The result register holds a finished
// word while the sink stalls, and the sequencer waits with the next result until
// it is free; configuration writes are always taken and must arrive while idle.

module axis_drive_ramp_model_core #(
    parameter int STOP_TICKS = adrm_pkg::STOP_TICKS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    adrm_in_if.sink         i_in,
    adrm_out_if.source      o_out,
    adrm_cfg_if.sink        i_cfg
);

    localparam int VW = adrm_pkg::VAL_W;
    localparam int SW = adrm_pkg::SUM_W;
    localparam int PW = adrm_pkg::PROD_W;
    localparam int IW = adrm_pkg::IDLE_W;
    localparam int MPROD_W = adrm_pkg::MUL_A_W + adrm_pkg::MUL_DIG_W + 1
        + ((adrm_pkg::MUL_B_W + adrm_pkg::MUL_DIG_W - 1) / adrm_pkg::MUL_DIG_W)
        * adrm_pkg::MUL_DIG_W;
    localparam logic [IW-1:0] STOP_LIM = IW'(STOP_TICKS);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_FILT   = 3'd3;
    localparam logic [2:0] S_LAUNCH = 3'd4;
    localparam logic [2:0] S_MUL2   = 3'd5;
    localparam logic [2:0] S_DELTA  = 3'd6;
    localparam logic [2:0] S_UPD    = 3'd7;

    // Configuration registers
    logic [adrm_pkg::RATE_W-1:0]  r_accel_rate, r_decel_rate, r_speed_band;
    logic [adrm_pkg::COEFF_W-1:0] r_filter_coeff;
    logic [adrm_pkg::Q16_W-1:0]   r_tick_period, r_zero_band, r_torque_fs;

    // Axis state
    logic signed [VW-1:0] r_filt, n_filt;
    logic signed [VW-1:0] r_speed, n_speed;
    logic        [IW-1:0] r_idle, n_idle;

    // Per-tick working registers
    logic [2:0]                  r_state, n_state;
    logic signed [VW-1:0]        r_cmd, n_cmd;
    logic                        r_ref_nz;
    logic                        r_brake;
    logic [adrm_pkg::Q16_W-1:0]  r_torque, n_torque;
    logic signed [SW-1:0]        r_delta, n_delta;

    // Result register
    logic                        r_out_valid;
    logic signed [VW-1:0]        r_out_cmd, r_out_filt, r_out_speed;
    logic [adrm_pkg::Q16_W-1:0]  r_out_torque;
    logic                        r_out_forced;

    // Multiplier hookup
    logic                                 mul_start, mul_busy, mul_done;
    logic signed [adrm_pkg::MUL_A_W-1:0]  mul_a;
    logic        [adrm_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [MPROD_W-1:0]            mul_prod;

    // Combinational helpers
    logic signed [VW:0]   err, band;
    logic                 ref_pos;
    logic [adrm_pkg::COEFF_W-1:0] coeff_sat;
    logic signed [PW-1:0] prod_rnd;
    logic signed [SW-1:0] y_sum, zb_wide, spd_sum;
    logic                 y_zero, accept, out_free, forced;
    logic [adrm_pkg::TQ_NUM_W-1:0]   tq_num;
    logic [2*adrm_pkg::TQ_NUM_W-1:0] tq_prod;

    assign accept   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // Register writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate   <= '0;
            r_decel_rate   <= '0;
            r_speed_band   <= '0;
            r_filter_coeff <= adrm_pkg::FILTER_COEFF_RST;
            r_tick_period  <= adrm_pkg::TICK_PERIOD_RST;
            r_zero_band    <= adrm_pkg::ZERO_BAND_RST;
            r_torque_fs    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                adrm_pkg::CFG_ACCEL_RATE:   r_accel_rate   <= i_cfg.data;
                adrm_pkg::CFG_DECEL_RATE:   r_decel_rate   <= i_cfg.data;
                adrm_pkg::CFG_SPEED_BAND:   r_speed_band   <= i_cfg.data;
                adrm_pkg::CFG_FILTER_COEFF: r_filter_coeff <= i_cfg.data[adrm_pkg::COEFF_W-1:0];
                adrm_pkg::CFG_TICK_PERIOD:  r_tick_period  <= i_cfg.data[adrm_pkg::Q16_W-1:0];
                adrm_pkg::CFG_ZERO_BAND:    r_zero_band    <= i_cfg.data[adrm_pkg::Q16_W-1:0];
                adrm_pkg::CFG_TORQUE_FS:    r_torque_fs    <= i_cfg.data[adrm_pkg::Q16_W-1:0];
                default: ;
            endcase
        end
    end

    // Pick the command from the speed error and clamp it at the end stops
    always_comb begin
        err     = $signed({i_in.speed_ref[VW-1], i_in.speed_ref})
                - $signed({r_speed[VW-1], r_speed});
        band    = $signed({2'b00, r_speed_band});
        ref_pos = !i_in.speed_ref[VW-1] && (i_in.speed_ref != '0);
        n_cmd   = '0;
        if (err > band) begin
            n_cmd = ref_pos ? $signed({1'b0, r_accel_rate}) : $signed({1'b0, r_decel_rate});
        end else if (err < -band) begin
            n_cmd = ref_pos ? -$signed({1'b0, r_decel_rate}) : -$signed({1'b0, r_accel_rate});
        end
        if ((n_cmd > 0) && i_in.fwd_endstop) begin
            n_cmd = '0;
        end
        if ((n_cmd < 0) && i_in.rev_endstop) begin
            n_cmd = '0;
        end
    end

    // Torque feedback: round(fs * pct / 10) by reciprocal multiply
    always_comb begin
        tq_num   = r_brake ? ({{(adrm_pkg::TQ_NUM_W-adrm_pkg::Q16_W-3){1'b0}}, r_torque_fs, 3'b000})
                           : ({{(adrm_pkg::TQ_NUM_W-adrm_pkg::Q16_W-1){1'b0}}, r_torque_fs, 1'b0}
                              + {{(adrm_pkg::TQ_NUM_W-adrm_pkg::Q16_W){1'b0}}, r_torque_fs});
        tq_num   = tq_num + adrm_pkg::TQ_ROUND;
        tq_prod  = tq_num * adrm_pkg::TQ_RECIP10;
        n_torque = (r_cmd != '0)
                 ? tq_prod[adrm_pkg::TQ_SHIFT +: adrm_pkg::Q16_W] : '0;
    end

    // Multiplier operands: lag step c*(cmd-f), then integration f*tick
    assign coeff_sat = (r_filter_coeff > adrm_pkg::COEFF_ONE)
                     ? adrm_pkg::COEFF_ONE : r_filter_coeff;
    assign mul_start = (r_state == S_PREP) || (r_state == S_LAUNCH);
    always_comb begin
        if (r_state == S_PREP) begin
            mul_a = $signed({r_cmd[VW-1], r_cmd}) - $signed({r_filt[VW-1], r_filt});
            mul_b = coeff_sat;
        end else begin
            mul_a = $signed({r_filt[VW-1], r_filt});
            mul_b = {{(adrm_pkg::MUL_B_W-adrm_pkg::Q16_W){1'b0}}, r_tick_period};
        end
    end

    adrm_serial_mul #(
        .A_W   (adrm_pkg::MUL_A_W),
        .B_W   (adrm_pkg::MUL_B_W),
        .DIG_W (adrm_pkg::MUL_DIG_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Round the product by half an LSB and drop sixteen fraction bits
    assign prod_rnd = $signed(mul_prod[PW-1:0]) + adrm_pkg::ROUND_HALF;

    // Lag filter result and zero band
    always_comb begin
        y_sum   = $signed({{(SW-VW){r_filt[VW-1]}}, r_filt}) + $signed(prod_rnd[PW-1:16]);
        zb_wide = $signed({{(SW-adrm_pkg::Q16_W){1'b0}}, r_zero_band});
        y_zero  = (y_sum < zb_wide) && (y_sum > -zb_wide);
        n_filt  = y_zero ? '0 : y_sum[VW-1:0];
        n_delta = $signed(prod_rnd[PW-1:16]);
    end

    // Speed update, saturation, stop timeout and idle count
    always_comb begin
        spd_sum = $signed({{(SW-VW){r_speed[VW-1]}}, r_speed}) + r_delta;
        if (spd_sum > adrm_pkg::SAT_MAX) begin
            n_speed = {1'b0, {(VW-1){1'b1}}};
        end else if (spd_sum < adrm_pkg::SAT_MIN) begin
            n_speed = {1'b1, {(VW-1){1'b0}}};
        end else begin
            n_speed = spd_sum[VW-1:0];
        end
        forced = (r_idle >= STOP_LIM);
        if (forced) begin
            n_speed = '0;
        end
        if (r_ref_nz) begin
            n_idle = '0;
        end else if (forced) begin
            n_idle = STOP_LIM;
        end else begin
            n_idle = r_idle + IW'(1);
        end
    end

    // Advance the tick sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept)   n_state = S_PREP;
            S_PREP:   n_state = S_MUL1;
            S_MUL1:   if (mul_done) n_state = S_FILT;
            S_FILT:   n_state = S_LAUNCH;
            S_LAUNCH: n_state = S_MUL2;
            S_MUL2:   if (mul_done) n_state = S_DELTA;
            S_DELTA:  n_state = S_UPD;
            S_UPD:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filt      <= '0;
            r_speed     <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FILT) begin
                r_filt <= n_filt;
            end
            if ((r_state == S_UPD) && out_free) begin
                r_speed     <= n_speed;
                r_idle      <= n_idle;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the tick's working values
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= n_cmd;
            r_ref_nz <= (i_in.speed_ref != '0);
            r_brake  <= i_in.brake_open;
        end
        if (r_state == S_PREP) begin
            r_torque <= n_torque;
        end
        if (r_state == S_DELTA) begin
            r_delta <= n_delta;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD) && out_free) begin
            r_out_cmd    <= r_cmd;
            r_out_filt   <= r_filt;
            r_out_speed  <= n_speed;
            r_out_torque <= r_torque;
            r_out_forced <= forced;
        end
    end

    assign i_in.ready              = (r_state == S_IDLE) && !mul_busy;
    assign i_cfg.ready             = 1'b1;
    assign o_out.valid             = r_out_valid;
    assign o_out.accel_cmd         = r_out_cmd;
    assign o_out.accel_filtered    = r_out_filt;
    assign o_out.speed_out         = r_out_speed;
    assign o_out.torque_out        = r_out_torque;
    assign o_out.speed_forced_zero = r_out_forced;

endmodule

`default_nettype wire

// ----- hdl/adrm_checker.sv -----
// Port-level checker for the axis drive ramp model, bound to the top level
`default_nettype none
`include "axis_drive_ramp_model_core_defines.svh"

module adrm_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_in_valid,
    input wire                                i_in_ready,
    input wire                                i_out_valid,
    input wire                                i_out_ready,
    input wire signed [adrm_pkg::VAL_W-1:0]   i_accel_cmd,
    input wire signed [adrm_pkg::VAL_W-1:0]   i_speed_out,
    input wire        [adrm_pkg::Q16_W-1:0]   i_torque_out,
    input wire                                i_forced
);

    // A stalled result word stays offered and unchanged
    `ADRM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_speed_out) && $stable(i_accel_cmd))

    // One tick at a time: ready drops after a word is taken
    `ADRM_ASSERT_NEXT(a_in_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)

    // No torque without a command
    `ADRM_ASSERT_NOW(a_torque_needs_cmd, i_out_valid && (i_accel_cmd == '0),
        i_torque_out == '0)

    // A forced stop reports zero speed
    `ADRM_ASSERT_NOW(a_forced_zero, i_out_valid && i_forced, i_speed_out == '0)

endmodule

bind axis_drive_ramp_model_core adrm_checker u_adrm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_accel_cmd  (o_out.accel_cmd),
    .i_speed_out  (o_out.speed_out),
    .i_torque_out (o_out.torque_out),
    .i_forced     (o_out.speed_forced_zero)
);

`default_nettype wire
